// ----- hdl/bpd_pkg.sv -----
// Shared types and constants for the bit-angle-modulation pin plane driver.
// No dependencies; used by every module in hdl/.
package bpd_pkg;

  localparam int PIN_COUNT = 16;
  localparam int PIN_W     = $clog2(PIN_COUNT);
  localparam int VAL_W     = 8;
  localparam int LEVEL_W   = 16;

  // Operation codes carried in s_tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PLANE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Request from the sequencer to the brightness store
  typedef struct packed {
    logic             we;
    logic             re;
    logic             clr;
    logic [PIN_W-1:0] addr;
    logic [VAL_W-1:0] wdata;
  } bpd_store_req_t;

endpackage

// ----- hdl/bam_pin_plane_driver_core.sv -----
// Bit-angle-modulation pin plane driver top level; uses bpd_pkg, bpd_store, bpd_curve.
// Steps from input transfer to result valid: write/clear EXEC, FIN; read EXEC, RDW,
// FIN; plane step EXEC, SCAN, DRAIN, LATCH, FIN. The plane step is set by the 16-entry
// scan of the store's single read port through the shared curve unit.
// One item in flight; FIN waits for the output, and a new input is taken only in IDLE.
// Reset (rst, synchronous): store reads as all zero, pin levels zero.
module bam_pin_plane_driver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // opcode
  input  logic [23:0] s_tdata,   // pin_index[3:0], pin_value[11:4], bit_mask[19:12], pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_value[7:0], pin_levels[23:8]
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_RDW   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_LATCH = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]                     state;
  logic [1:0]                     op;
  logic [bpd_pkg::PIN_W-1:0]      pin;
  logic [bpd_pkg::VAL_W-1:0]      value;
  logic [bpd_pkg::VAL_W-1:0]      mask;
  logic [bpd_pkg::PIN_W-1:0]      cnt;
  logic                           rd_pend;
  logic [bpd_pkg::PIN_W-1:0]      rd_idx;
  logic [bpd_pkg::LEVEL_W-1:0]    lev_acc;
  logic [bpd_pkg::LEVEL_W-1:0]    levels;
  logic [bpd_pkg::VAL_W-1:0]      res_value;
  logic [bpd_pkg::VAL_W-1:0]      rdata;
  logic                           hit;
  bpd_pkg::bpd_store_req_t        req;

  assign s_tready = (state == ST_IDLE);

  // Store requests from the sequencer
  always_comb begin
    req.we    = (state == ST_EXEC) && (op == bpd_pkg::OP_WRITE);
    req.clr   = (state == ST_EXEC) && (op == bpd_pkg::OP_CLEAR);
    req.re    = ((state == ST_EXEC) && (op == bpd_pkg::OP_READ)) || (state == ST_SCAN);
    req.addr  = (state == ST_SCAN) ? cnt : pin;
    req.wdata = value;
  end

  bpd_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  bpd_curve u_curve (
    .value (rdata),
    .mask  (mask),
    .hit   (hit)
  );

  // Input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op    <= s_tuser;
      pin   <= s_tdata[3:0];
      value <= s_tdata[11:4];
      mask  <= s_tdata[19:12];
    end
  end

  // Plane accumulator: one pin level per returned store read
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      lev_acc[rd_idx] <= hit;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      rd_pend  <= 1'b0;
      rd_idx   <= '0;
      levels   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result transfer drops valid unless a new result is issued this cycle
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      rd_pend <= (state == ST_SCAN);
      rd_idx  <= cnt;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            res_value <= '0;
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op)
            bpd_pkg::OP_READ:  state <= ST_RDW;
            bpd_pkg::OP_PLANE: begin
              cnt   <= '0;
              state <= ST_SCAN;
            end
            bpd_pkg::OP_CLEAR: begin
              levels <= '0;
              state  <= ST_FIN;
            end
            default:           state <= ST_FIN;
          endcase
        end
        ST_RDW: begin
          res_value <= rdata;
          state     <= ST_FIN;
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == bpd_pkg::PIN_W'(bpd_pkg::PIN_COUNT - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          levels <= lev_acc;
          state  <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && (!m_tvalid || m_tready)) begin
      m_tdata <= {levels, res_value};
    end
  end

endmodule

// ----- hdl/bpd_store.sv -----
// Brightness store: 16 x 8 synchronous memory with registered read.
// Per-entry valid bits give the all-zero reset and the clear of all entries at once.
// Depends on bpd_pkg.
module bpd_store (
  input  logic                        clk,
  input  logic                        rst,
  input  bpd_pkg::bpd_store_req_t     req,
  output logic [bpd_pkg::VAL_W-1:0]   rdata
);

  logic [bpd_pkg::VAL_W-1:0]     mem [bpd_pkg::PIN_COUNT];
  logic [bpd_pkg::PIN_COUNT-1:0] valid;

  // Valid bits: cleared by reset or a clear, set on write
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.addr] <= 1'b1;
    end
  end

  // Data array write
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Registered read; never-written entries read as zero
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= valid[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule

// ----- hdl/bpd_curve.sv -----
// Shared brightness curve unit and bit-plane mask test.
// Depends on bpd_pkg.
module bpd_curve (
  input  logic [bpd_pkg::VAL_W-1:0] value,
  input  logic [bpd_pkg::VAL_W-1:0] mask,
  output logic                      hit
);

  logic [6:0]                high_off;
  logic [8:0]                high_x3;
  logic [bpd_pkg::VAL_W-1:0] low_off;
  logic [bpd_pkg::VAL_W-1:0] curved;

  // Piecewise curve: steep segment above 128, half slope above 16, else v/2
  always_comb begin
    high_off = value[6:0];                          // v - 128 when v > 128
    high_x3  = {1'b0, high_off, 1'b0} + {2'b00, high_off};
    low_off  = value - 8'd16;
    if (value > 8'd128) begin
      curved = 8'd64 + high_x3[8:1];
    end else if (value > 8'd16) begin
      curved = 8'd8 + {1'b0, low_off[7:1]};
    end else begin
      curved = {1'b0, value[7:1]};
    end
    hit = |(curved & mask);
  end

endmodule
